FILE: src/idqs_pkg.sv
// Shared constants and types of the indexed deque store.
`default_nettype none

package idqs_pkg;

	localparam int DATA_W = 32;
	localparam int ACT_W  = 3;
	localparam int POS_W  = 10;
	localparam int CNT_W  = 11;
	localparam int ST_W   = 2;

	localparam logic [ACT_W-1:0] ACT_PUSH    = 3'd0;
	localparam logic [ACT_W-1:0] ACT_POP     = 3'd1;
	localparam logic [ACT_W-1:0] ACT_UNSHIFT = 3'd2;
	localparam logic [ACT_W-1:0] ACT_SHIFT   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_GET     = 3'd4;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

	localparam logic [DATA_W-1:0] ERR_WORD = '1;

	// Per-transaction result information that travels beside the RAM read.
	typedef struct packed {
		logic            rd;
		logic [ST_W-1:0] status;
	} info_t;

endpackage

`default_nettype wire

FILE: src/idqs_ram.sv
// Single-port element RAM with registered read data.
`default_nettype none

module idqs_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  wire logic                           clk,
	input  wire logic                           we,
	input  wire logic                           re,
	input  wire logic [AW-1:0]                  addr,
	input  wire logic [idqs_pkg::DATA_W-1:0]    wdata,
	output logic      [idqs_pkg::DATA_W-1:0]    rdata
);

	logic [idqs_pkg::DATA_W-1:0] mem [DEPTH];
	logic [idqs_pkg::DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: src/idqs_ctrl.sv
// Front pointer and count registers with action decode and RAM address generation.
`default_nettype none

module idqs_ctrl #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int CW    = 11
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           accept,
	input  wire logic [idqs_pkg::ACT_W-1:0]     action,
	input  wire logic [idqs_pkg::DATA_W-1:0]    value,
	input  wire logic [idqs_pkg::POS_W-1:0]     position,
	output logic                                mem_we,
	output logic                                mem_re,
	output logic      [AW-1:0]                  mem_addr,
	output logic      [idqs_pkg::DATA_W-1:0]    mem_wdata,
	output idqs_pkg::info_t                     info,
	output logic      [idqs_pkg::CNT_W-1:0]     count_next
);

	localparam int PW = (CW > idqs_pkg::POS_W) ? CW : idqs_pkg::POS_W;
	localparam logic [AW:0]   DEPTH_W = (AW+1)'(DEPTH);
	localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);

	logic [AW-1:0] front_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] front_nx;
	logic [CW-1:0] count_nx;
	logic [AW-1:0] off;
	logic [AW:0]   sum;
	logic [AW-1:0] slot;
	logic [AW-1:0] front_dec;
	logic [AW-1:0] front_inc;
	logic          full;
	logic          empty;
	logic          in_range;
	logic          wr;
	logic          rd;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign in_range = (PW'(position) < PW'(count_q));

	assign front_dec = (front_q == '0)   ? LAST : front_q - AW'(1);
	assign front_inc = (front_q == LAST) ? '0   : front_q + AW'(1);

	// Offset from the front; only used where it is below DEPTH.
	always_comb begin
		unique case (action)
			idqs_pkg::ACT_PUSH: off = count_q[AW-1:0];
			idqs_pkg::ACT_POP:  off = AW'(count_q - CW'(1));
			idqs_pkg::ACT_GET:  off = AW'(position);
			default:            off = '0;
		endcase
	end

	// Wrap front + offset modulo DEPTH with one compare and subtract.
	assign sum  = {1'b0, front_q} + {1'b0, off};
	assign slot = (sum >= DEPTH_W) ? AW'(sum - DEPTH_W) : sum[AW-1:0];

	always_comb begin
		wr          = 1'b0;
		rd          = 1'b0;
		mem_addr    = slot;
		info.rd     = 1'b0;
		info.status = idqs_pkg::ST_OK;
		front_nx    = front_q;
		count_nx    = count_q;
		unique case (action)
			idqs_pkg::ACT_PUSH: begin
				if (full) begin
					info.status = idqs_pkg::ST_FULL;
				end else begin
					wr       = 1'b1;
					count_nx = count_q + CW'(1);
				end
			end
			idqs_pkg::ACT_POP: begin
				if (empty) begin
					info.status = idqs_pkg::ST_EMPTY;
				end else begin
					rd       = 1'b1;
					count_nx = count_q - CW'(1);
				end
			end
			idqs_pkg::ACT_UNSHIFT: begin
				mem_addr = front_dec;
				if (full) begin
					info.status = idqs_pkg::ST_FULL;
				end else begin
					wr       = 1'b1;
					front_nx = front_dec;
					count_nx = count_q + CW'(1);
				end
			end
			idqs_pkg::ACT_SHIFT: begin
				mem_addr = front_q;
				if (empty) begin
					info.status = idqs_pkg::ST_EMPTY;
				end else begin
					rd       = 1'b1;
					front_nx = front_inc;
					count_nx = count_q - CW'(1);
				end
			end
			idqs_pkg::ACT_GET: begin
				if (!in_range) begin
					info.status = idqs_pkg::ST_RANGE;
				end else begin
					rd = 1'b1;
				end
			end
			default: begin
			end
		endcase
		info.rd = rd;
	end

	assign mem_we     = accept && wr;
	assign mem_re     = accept && rd;
	assign mem_wdata  = value;
	assign count_next = idqs_pkg::CNT_W'(count_nx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			front_q <= front_nx;
			count_q <= count_nx;
		end
	end

endmodule

`default_nettype wire

FILE: src/indexed_deque_store_core.sv
// Top level of the indexed deque store: RAM, control and result pipeline.
// Results: an accepted transaction waits in stage 1 for the registered RAM read,
// then moves to the output register. Throughput: one transaction per cycle while
// in_stall is low; every action makes at most one access to the single-port element RAM.
// Reset: front pointer, count and pipeline valid flags clear; the element RAM
// is not cleared and needs no clearing pass, as only written entries are read.
`default_nettype none

module indexed_deque_store_core #(
	parameter int DEPTH = 1024
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic        [idqs_pkg::ACT_W-1:0]    action,
	input  wire logic signed [idqs_pkg::DATA_W-1:0]   value,
	input  wire logic        [idqs_pkg::POS_W-1:0]    position,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed      [idqs_pkg::DATA_W-1:0]   data,
	output logic             [idqs_pkg::ST_W-1:0]     status,
	output logic             [idqs_pkg::CNT_W-1:0]    count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic                             accept;
	logic                             mem_we;
	logic                             mem_re;
	logic [AW-1:0]                    mem_addr;
	logic [idqs_pkg::DATA_W-1:0]      mem_wdata;
	logic [idqs_pkg::DATA_W-1:0]      mem_rdata;
	idqs_pkg::info_t                  info;
	logic [idqs_pkg::CNT_W-1:0]       count_next;

	// Stage 1: transaction waiting for its RAM read data.
	logic                             valid_s1;
	idqs_pkg::info_t                  info_s1;
	logic [idqs_pkg::CNT_W-1:0]       count_s1;

	// Output register.
	logic                             out_valid_q;
	logic [idqs_pkg::DATA_W-1:0]      data_q;
	logic [idqs_pkg::ST_W-1:0]        status_q;
	logic [idqs_pkg::CNT_W-1:0]       count_q;

	logic                             out_free;
	logic                             s1_adv;
	logic [idqs_pkg::DATA_W-1:0]      data_s1;

	// The output register frees when empty or when its result is taken this cycle.
	assign out_free = !out_valid_q || !out_stall;
	assign s1_adv   = valid_s1 && out_free;
	// Hold the input while stage 1 is blocked: its RAM read data must not be overwritten.
	assign in_stall = valid_s1 && !out_free;
	assign accept   = in_valid && !in_stall;

	idqs_ctrl #(
		.DEPTH(DEPTH),
		.AW   (AW),
		.CW   (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.action    (action),
		.value     ($unsigned(value)),
		.position  (position),
		.mem_we    (mem_we),
		.mem_re    (mem_re),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.info      (info),
		.count_next(count_next)
	);

	idqs_ram #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.re   (mem_re),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	// Errors return all ones; successful inserts and unused actions return zero.
	always_comb begin
		priority if (info_s1.status != idqs_pkg::ST_OK) begin
			data_s1 = idqs_pkg::ERR_WORD;
		end else if (info_s1.rd) begin
			data_s1 = mem_rdata;
		end else begin
			data_s1 = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: advance with their valid flags, no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			info_s1  <= info;
			count_s1 <= count_next;
		end
		if (s1_adv) begin
			data_q   <= data_s1;
			status_q <= info_s1.status;
			count_q  <= count_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign data      = $signed(data_q);
	assign status    = status_q;
	assign count     = count_q;

endmodule

`default_nettype wire
